// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

	// Field widths of the stream channels.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W = 21;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned POLICY_W = 2;

	// Error policy codes. Any other code behaves like stop.
	localparam logic [POLICY_W-1:0] POLICY_REPLACE = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_RAISE = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_STOP = 2'd2;

	// Code point limits.
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MIN_2BYTE = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3BYTE = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4BYTE = 21'h010000;
	localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic blocked;
		logic hold_valid;
		logic [CNT_W-1:0] count;
	} dp_status_t;

	// Sequence length implied by a lead byte; zero for an invalid lead.
	function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		if (b[7] == 1'b0) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage

// ===== rtl/utf8d_ctrl.sv =====
module utf8d_ctrl import utf8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  dp_status_t  status,
	output ctrl_cmd_t   cmd,
	output ctrl_state_t state
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands. The scan takes one decoding step per cycle and
	// waits whenever the held result cannot move into the output register.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!status.blocked) begin
					if (status.done) begin
						cmd.finish = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

// ===== rtl/utf8d_datapath.sv =====
module utf8d_datapath import utf8d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [POLICY_W-1:0] cfg_wr_data,
	input  logic [BYTE_W-1:0]   in_byte,
	input  logic                in_eot,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          status,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [CP_W-1:0]     out_cp,
	output logic                out_error,
	output logic                out_last,
	output logic                out_done
);

	// Buffered bytes, oldest in the lowest byte.
	logic [3:0][BYTE_W-1:0] buf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   eot_q;
	logic                   halted_q;
	logic [POLICY_W-1:0]    policy_q;

	// Result held until it is known whether another one follows.
	logic                   hold_valid_q;
	logic [CP_W-1:0]        hold_cp_q;
	logic                   hold_err_q;

	// Output register.
	logic                   out_valid_q;
	logic [CP_W-1:0]        out_cp_q;
	logic                   out_err_q;
	logic                   out_last_q;
	logic                   out_done_q;

	logic [LEN_W-1:0]       len;
	logic [CNT_W-1:0]       lim;
	logic                   trail_bad;
	logic                   incomplete;
	logic                   range_bad;
	logic                   bad;
	logic [CP_W-1:0]        cp;
	logic                   res_valid;
	logic [CP_W-1:0]        res_cp;
	logic                   res_err;
	logic [LEN_W-1:0]       shift;
	logic                   halt_now;
	logic                   out_free;
	logic                   push;
	logic                   push_last;

	// Evaluate the sequence at the head of the buffer.
	always_comb begin
		len = lead_len(buf_q[0]);
		lim = (cnt_q < len) ? cnt_q : len;
		incomplete = cnt_q < len;
		trail_bad = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if ((CNT_W'(i) < lim) && (buf_q[i][7:6] != 2'b10)) begin
				trail_bad = 1'b1;
			end
		end
		case (len)
			3'd1: cp = {14'd0, buf_q[0][6:0]};
			3'd2: cp = {10'd0, buf_q[0][4:0], buf_q[1][5:0]};
			3'd3: cp = {5'd0, buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
			3'd4: cp = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
			default: cp = '0;
		endcase
		range_bad = ((len == 3'd2) && (cp < CP_MIN_2BYTE)) ||
			((len == 3'd3) && (cp < CP_MIN_3BYTE)) ||
			((len == 3'd4) && (cp < CP_MIN_4BYTE)) ||
			((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI)) ||
			(cp > CP_MAX);
		bad = (len == 3'd0) || trail_bad || (incomplete && eot_q) ||
			(!incomplete && range_bad);
	end

	// Action of one decoding step, chosen by the error policy.
	always_comb begin
		res_valid = 1'b1;
		res_cp = cp;
		res_err = 1'b0;
		shift = len;
		halt_now = 1'b0;
		if (bad) begin
			case (policy_q)
				POLICY_REPLACE: begin
					res_cp = CP_REPLACEMENT;
					shift = 3'd1;
				end
				POLICY_RAISE: begin
					res_cp = '0;
					res_err = 1'b1;
					halt_now = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
					halt_now = 1'b1;
				end
			endcase
		end
	end

	// The held result moves to the output when a newer result or the end of
	// the item's scan shows whether it was the last one.
	assign out_free = !out_valid_q || out_ready;
	assign push = hold_valid_q && ((cmd.step && res_valid) || cmd.finish);
	assign push_last = cmd.finish;

	// Policy register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_REPLACE;
		end else if (cfg_wr_en) begin
			policy_q <= cfg_wr_data;
		end
	end

	// Buffer contents.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= in_byte;
		end else if (cmd.step && !halt_now) begin
			buf_q <= buf_q >> {shift, 3'b000};
		end
	end

	// Buffer control, halt flag and held result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			eot_q <= 1'b0;
			halted_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				eot_q <= in_eot;
				cnt_q <= halted_q ? '0 : cnt_q + CNT_W'(1);
			end else if (cmd.step) begin
				if (halt_now) begin
					cnt_q <= '0;
					halted_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - shift;
				end
				if (res_valid) begin
					hold_valid_q <= 1'b1;
				end
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
				if (eot_q) begin
					cnt_q <= '0;
					halted_q <= 1'b0;
				end
			end
		end
	end

	// Held result payload.
	always_ff @(posedge clk) begin
		if (cmd.step && res_valid) begin
			hold_cp_q <= res_cp;
			hold_err_q <= res_err;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (push) begin
			out_cp_q <= hold_cp_q;
			out_err_q <= hold_err_q;
			out_last_q <= push_last;
			out_done_q <= eot_q;
		end
	end

	assign status.done = (cnt_q == '0) ||
		((len != 3'd0) && !trail_bad && incomplete && !eot_q);
	assign status.blocked = hold_valid_q && !out_free;
	assign status.hold_valid = hold_valid_q;
	assign status.count = cnt_q;

	assign out_valid = out_valid_q;
	assign out_cp = out_cp_q;
	assign out_error = out_err_q;
	assign out_last = out_last_q;
	assign out_done = out_done_q;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder.
// The slave channel takes one text byte per item in s_axis_tdata, with
// s_axis_tlast high on the final byte of the text. The master channel gives
// one result per item: the decoded value in m_axis_tdata, m_axis_tlast high on
// the last result caused by an input byte, and m_axis_tuser flags for a
// raised decode error and for results caused by the final byte.
// cfg_wr_en writes the error policy from cfg_wr_data (replace, raise, stop).
// Each input byte is followed by its decoding steps before the next byte can be
// accepted: one step per result (up to four), and one more for an error that
// halts without a result. A byte that only extends a buffered sequence, or
// arrives while halted, needs no decoding step.
// The decoding step handles one sequence a cycle while the output is not stalled,
// and each result is held until it is known to be the last.
// Results reach the master side through the hold register and the output register.
// Reset empties the buffer, clears the halt state and sets the policy to
// replace. When the receiver stalls, the output register holds its result
// and decoding waits; the slave side is not ready until the current byte's
// results have all entered the output register.
module utf8_stream_decoder import utf8d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [POLICY_W-1:0] cfg_wr_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
	input  logic                s_axis_tlast,   // end_of_text
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,   // [20:0] decoded value, [23:21] zero
	output logic                m_axis_tlast,   // run_last
	output logic [1:0]          m_axis_tuser    // [0] decode_error, [1] text_done
);

	ctrl_cmd_t   cmd;
	dp_status_t  status;
	ctrl_state_t state;
	logic [CP_W-1:0] dec_cp;
	logic        decode_error;
	logic        text_done;

	utf8d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	utf8d_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_byte        (s_axis_tdata),
		.in_eot         (s_axis_tlast),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_cp         (dec_cp),
		.out_error      (decode_error),
		.out_last       (m_axis_tlast),
		.out_done       (text_done)
	);

	assign m_axis_tdata = {3'b000, dec_cp};
	assign m_axis_tuser = {text_done, decode_error};

	// Every result of the previous byte has left the hold stage before a new
	// byte is taken.
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_IDLE) |-> !status.hold_valid)
		else $error("held result left behind at end of scan");

	// Between items the buffer keeps at most three bytes.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_IDLE) |-> (status.count <= CNT_W'(3)))
		else $error("buffer count out of range between items");

	// Only one datapath command is issued per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.finish}))
		else $error("conflicting datapath commands");

	// A step or finish never overwrites a result that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.finish) && status.hold_valid && m_axis_tvalid |->
		m_axis_tready)
		else $error("output register overwritten while stalled");

endmodule

// ===== verif/tb_utf8_stream_decoder.sv =====
module tb_utf8_stream_decoder;
	import utf8d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_PRINTS = 40;
	localparam int PHASE_BYTES = 25;

	// The fourth policy code has no name in the package; it behaves like stop.
	localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

	// One decoded result as seen on the master side.
	typedef struct {
		logic [CP_W-1:0] cp;
		logic            err;
		logic            run_last;
		logic            text_done;
	} cp_result_t;

	// One byte of text with its end-of-text flag.
	typedef struct {
		logic [7:0] b;
		logic       eot;
	} text_byte_t;

	// A directed row; typed rows carry the single result they must cause.
	typedef struct {
		logic [POLICY_W-1:0] policy;
		logic [7:0]          b;
		logic                eot;
		bit                  typed;
		logic [CP_W-1:0]     cp;
		logic                err;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [POLICY_W-1:0] cfg_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [23:0]         m_axis_tdata;
	logic                m_axis_tlast;
	logic [1:0]          m_axis_tuser;

	// Decoder state mirrored by the testbench.
	logic [7:0]          pend_bytes [3];
	int                  pend_n;
	logic                halted_q;
	logic [POLICY_W-1:0] policy_q;

	cp_result_t  step_res [4];
	int          step_cnt;
	cp_result_t  cp_expect_q [$];
	text_byte_t  text_q [$];

	int  mismatches;
	int  snd_idle_pct;
	int  rcv_idle_pct;
	bit  hold_req;
	int  quiet_cycles;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Replace policy: extremes of the one-byte range.
		'{POLICY_REPLACE, 8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
		'{POLICY_REPLACE, 8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
		// Smallest two-byte value.
		'{POLICY_REPLACE, 8'hC2, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h80, 1'b0, 1'b0, '0, 1'b0},
		// Largest scalar value.
		'{POLICY_REPLACE, 8'hF4, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h8F, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'hBF, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'hBF, 1'b0, 1'b0, '0, 1'b0},
		// Just above the largest value: four replacements from the last byte.
		'{POLICY_REPLACE, 8'hF4, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h90, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h80, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h80, 1'b0, 1'b0, '0, 1'b0},
		// A non-continuation byte is caught as soon as it arrives.
		'{POLICY_REPLACE, 8'hE2, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h41, 1'b0, 1'b0, '0, 1'b0},
		// Invalid lead byte.
		'{POLICY_REPLACE, 8'hFF, 1'b0, 1'b1, CP_REPLACEMENT, 1'b0},
		// Sequence cut short by the end of text.
		'{POLICY_REPLACE, 8'hF0, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_REPLACE, 8'h9F, 1'b1, 1'b0, '0, 1'b0},
		// Raise: one error result, then input is ignored until end of text.
		'{POLICY_RAISE, 8'hF8, 1'b0, 1'b1, 21'h000000, 1'b1},
		'{POLICY_RAISE, 8'h41, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_RAISE, 8'h42, 1'b1, 1'b0, '0, 1'b0},
		// Stop: an overlong form ends output silently.
		'{POLICY_STOP, 8'hC0, 1'b0, 1'b0, '0, 1'b0},
		'{POLICY_STOP, 8'h80, 1'b1, 1'b0, '0, 1'b0},
		// The spare policy code decodes good text and stops on truncation.
		'{POLICY_SPARE, 8'h41, 1'b1, 1'b1, 21'h000041, 1'b0},
		'{POLICY_SPARE, 8'hE1, 1'b1, 1'b0, '0, 1'b0}
	};

	utf8_stream_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
	end

	always #CLK_HALF clk = ~clk;

	// Sequence length announced by a lead byte, zero when it cannot lead.
	function automatic int seq_length(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	// Decode one accepted byte and leave its results in step_res.
	task automatic decode_byte(input logic [7:0] b, input logic eot);
		logic [7:0]  pending [4];
		logic [31:0] val;
		int          n;
		int          len;
		int          lim;
		bit          bad;

		for (int i = 0; i < 3; i++) begin
			pending[i] = pend_bytes[i];
		end
		pending[3] = 8'h00;
		n = pend_n;
		pending[n] = b;
		n++;
		step_cnt = 0;
		if (halted_q) begin
			n = 0;
		end

		while (n > 0) begin
			len = seq_length(pending[0]);
			bad = 1'b0;
			val = '0;
			if (len == 0) begin
				bad = 1'b1;
			end else begin
				lim = (n < len) ? n : len;
				for (int i = 1; i < lim; i++) begin
					if (pending[i][7:6] != 2'b10) begin
						bad = 1'b1;
					end
				end
				// An incomplete sequence waits for more bytes unless the text ends.
				if (!bad && n < len) begin
					if (eot) begin
						bad = 1'b1;
					end else begin
						break;
					end
				end
				if (!bad) begin
					case (len)
						1: val = {24'd0, pending[0]};
						2: val = {27'd0, pending[0][4:0]};
						3: val = {28'd0, pending[0][3:0]};
						default: val = {29'd0, pending[0][2:0]};
					endcase
					for (int i = 1; i < len; i++) begin
						val = {val[25:0], pending[i][5:0]};
					end
					if ((len == 2 && val < 32'h80) || (len == 3 && val < 32'h800) ||
							(len == 4 && val < 32'h10000)) begin
						bad = 1'b1;
					end else if (val >= 32'hD800 && val <= 32'hDFFF) begin
						bad = 1'b1;
					end else if (val > 32'h10FFFF) begin
						bad = 1'b1;
					end
				end
			end

			if (!bad) begin
				step_res[step_cnt] = '{cp: val[CP_W-1:0], err: 1'b0,
					run_last: 1'b0, text_done: 1'b0};
				step_cnt++;
				for (int i = 0; i < n - len; i++) begin
					pending[i] = pending[i + len];
				end
				n -= len;
			end else if (policy_q == POLICY_REPLACE) begin
				step_res[step_cnt] = '{cp: CP_REPLACEMENT, err: 1'b0,
					run_last: 1'b0, text_done: 1'b0};
				step_cnt++;
				for (int i = 0; i < n - 1; i++) begin
					pending[i] = pending[i + 1];
				end
				n -= 1;
			end else begin
				if (policy_q == POLICY_RAISE) begin
					step_res[step_cnt] = '{cp: '0, err: 1'b1,
						run_last: 1'b0, text_done: 1'b0};
					step_cnt++;
				end
				n = 0;
				halted_q = 1'b1;
			end
		end

		// End of text always drains the buffer and releases a halt.
		if (eot) begin
			n = 0;
			halted_q = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			pend_bytes[i] = pending[i];
		end
		pend_n = n;
		for (int k = 0; k < step_cnt; k++) begin
			step_res[k].run_last = (k == step_cnt - 1);
			step_res[k].text_done = eot;
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < MAX_PRINTS) begin
			$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// Offer one byte, wait for it to be taken and record what it must cause.
	task automatic send_item(input logic [7:0] b, input logic eot, input bit typed,
			input logic [CP_W-1:0] typed_cp, input logic typed_err);
		while ($urandom_range(99, 0) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		do begin
			@(posedge clk);
		end while (s_axis_tready !== 1'b1);
		decode_byte(b, eot);
		if (typed) begin
			cp_expect_q.insert(cp_expect_q.size(), '{cp: typed_cp, err: typed_err,
				run_last: 1'b1, text_done: eot});
		end else begin
			for (int k = 0; k < step_cnt; k++) begin
				cp_expect_q.insert(cp_expect_q.size(), step_res[k]);
			end
		end
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (cp_expect_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write the error policy once the block has gone quiet.
	task automatic set_policy(input logic [POLICY_W-1:0] p);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		policy_q = p;
	endtask

	// Append one sequence: mostly well formed, some invalid, some broken.
	task automatic add_sequence();
		int          kind;
		int          len;
		int          pos;
		int          pick;
		logic [20:0] cp;
		logic [7:0]  enc [4];
		int          lo [5];
		int          hi [5];

		lo = '{0, 32'h0, 32'h80, 32'h800, 32'h10000};
		hi = '{0, 32'h7F, 32'h7FF, 32'hFFFF, 32'h10FFFF};
		kind = $urandom_range(99, 0);
		if (kind < 12) begin
			text_q.insert(text_q.size(), '{b: 8'($urandom_range(255, 0)), eot: 1'b0});
			return;
		end
		len = $urandom_range(4, 1);
		pick = $urandom_range(7, 0);
		if (pick == 0) begin
			cp = 21'(lo[len]);
		end else if (pick == 1) begin
			cp = 21'(hi[len]);
		end else begin
			cp = 21'($urandom_range(hi[len], lo[len]));
		end
		if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
			cp = cp & 21'h007FFF;
		end
		if (kind >= 70) begin
			case ($urandom_range(3, 0))
				0: begin
					// Overlong form of a smaller value.
					if (len == 1) begin
						len = 2;
					end
					cp = 21'($urandom_range(lo[len] - 1, 0));
				end
				1: begin
					len = 3;
					cp = 21'($urandom_range(32'hDFFF, 32'hD800));
				end
				2: begin
					len = 4;
					cp = 21'($urandom_range(32'h1FFFFF, 32'h110000));
				end
				default: ;
			endcase
		end
		case (len)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		// Broken sequences: cut short or with a bad continuation byte.
		if (kind >= 88 && len > 1) begin
			pos = $urandom_range(len - 1, 1);
			if ($urandom_range(1, 0) == 1) begin
				len = pos;
			end else begin
				enc[pos] = 8'($urandom_range(255, 0));
				if (enc[pos][7:6] == 2'b10) begin
					enc[pos][6] = 1'b1;
				end
			end
		end
		for (int i = 0; i < len; i++) begin
			text_q.insert(text_q.size(), '{b: enc[i], eot: 1'b0});
		end
	endtask

	// Build texts of a few sequences each until enough bytes wait, then send them.
	task automatic send_texts(input int nbytes);
		text_byte_t tb_item;
		int         nseq;

		while (text_q.size() < nbytes) begin
			nseq = $urandom_range(10, 1);
			repeat (nseq) add_sequence();
			text_q[text_q.size() - 1].eot = 1'b1;
		end
		while (text_q.size() > 0) begin
			tb_item = text_q.pop_front();
			send_item(tb_item.b, tb_item.eot, 1'b0, '0, 1'b0);
		end
	endtask

	// Receiver: random stalls, and one long hold-off once it is requested.
	initial begin
		bit hold_done;

		hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
			end
		end
	end

	// Result checker: each item is compared with the oldest expectation.
	always @(posedge clk) begin
		cp_result_t want;

		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (cp_expect_q.size() == 0) begin
				report("unexpected result, value", 32'(m_axis_tdata[20:0]), '0);
			end else begin
				want = cp_expect_q.pop_front();
				if (m_axis_tdata[20:0] !== want.cp) begin
					report("decoded value", 32'(m_axis_tdata[20:0]), 32'(want.cp));
				end
				if (m_axis_tdata[23:21] !== 3'b000) begin
					report("tdata padding", 32'(m_axis_tdata[23:21]), '0);
				end
				if (m_axis_tuser[0] !== want.err) begin
					report("decode_error", 32'(m_axis_tuser[0]), 32'(want.err));
				end
				if (m_axis_tlast !== want.run_last) begin
					report("run_last", 32'(m_axis_tlast), 32'(want.run_last));
				end
				if (m_axis_tuser[1] !== want.text_done) begin
					report("text_done", 32'(m_axis_tuser[1]), 32'(want.text_done));
				end
			end
		end
	end

	// Watchdog: too many cycles without any item moving ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed rows, then random phases.
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= POLICY_REPLACE;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tlast <= 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		snd_idle_pct = 17;
		rcv_idle_pct = 54;
		pend_bytes = '{8'h00, 8'h00, 8'h00};
		pend_n = 0;
		halted_q = 1'b0;
		policy_q = POLICY_REPLACE;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].policy != policy_q) begin
				set_policy(dir_rows[r].policy);
			end
			send_item(dir_rows[r].b, dir_rows[r].eot, dir_rows[r].typed,
				dir_rows[r].cp, dir_rows[r].err);
		end

		// Sender idles lightly, receiver heavily.
		set_policy(POLICY_RAISE);
		send_texts(2 * PHASE_BYTES);
		set_policy(POLICY_STOP);
		send_texts(2 * PHASE_BYTES);

		// Roles swapped; one pause in the middle lets the block run dry.
		snd_idle_pct = 54;
		rcv_idle_pct = 17;
		set_policy(POLICY_SPARE);
		send_texts(2 * PHASE_BYTES);
		set_policy(POLICY_REPLACE);
		send_texts(PHASE_BYTES);
		wait_drain();
		send_texts(PHASE_BYTES);

		// No idling; a long receiver hold-off backs the block up to its input.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_policy(POLICY_RAISE);
		send_texts(2 * PHASE_BYTES);
		set_policy(POLICY_REPLACE);
		send_texts(PHASE_BYTES);
		hold_req = 1'b1;
		send_texts(PHASE_BYTES);

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (cp_expect_q.size() != 0) begin
			report("results left over", 32'(cp_expect_q.size()), '0);
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
